### hw/rtl/cbz_pkg.sv
// cubic bezier point generator: shared types and constants
// holds datapath widths, the multiplier operation codes, controller states and the command struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbz_pkg;

  // step counter and curve parameter width (steps up to 255)
  localparam int KW = 8;
  // control point and result coordinate width
  localparam int PW = 10;
  // weight width: every Bernstein weight is at most steps cubed
  localparam int WW = 24;
  // product and sum width: coordinate times steps cubed
  localparam int SW = WW + PW;
  // intermediate a*a, k*k, 3*a*k
  localparam int IW = 18;
  // configuration register index width (room for writes past the list)
  localparam int CIW = 4;

  localparam logic [CIW-1:0] REG_X0 = 4'd0;
  localparam logic [CIW-1:0] REG_X1 = 4'd1;
  localparam logic [CIW-1:0] REG_X2 = 4'd2;
  localparam logic [CIW-1:0] REG_X3 = 4'd3;
  localparam logic [CIW-1:0] REG_Y0 = 4'd4;
  localparam logic [CIW-1:0] REG_Y1 = 4'd5;
  localparam logic [CIW-1:0] REG_Y2 = 4'd6;
  localparam logic [CIW-1:0] REG_Y3 = 4'd7;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_AA,
    OP_KK,
    OP_AK3,
    OP_W0,
    OP_W3,
    OP_W1,
    OP_W2,
    OP_P0X,
    OP_P1X,
    OP_P2X,
    OP_P3X,
    OP_P0Y,
    OP_P1Y,
    OP_P2Y,
    OP_P3Y
  } mul_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AA,
    ST_KK,
    ST_AK3,
    ST_W0,
    ST_W3,
    ST_W1,
    ST_W2,
    ST_P0X,
    ST_P1X,
    ST_P2X,
    ST_P3X,
    ST_P0Y,
    ST_P1Y,
    ST_P2Y,
    ST_P3Y,
    ST_FLUSH,
    ST_DIV_EST,
    ST_DIV_REM,
    ST_DIV_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    accept;
    mul_op_t op;
    logic    div_est;
    logic    div_rem;
    logic    div_fix;
    logic    out_load;
  } cbz_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/cbz_ctrl.sv
// cubic bezier point generator: sequencing state machine
// walks the shared multiplier through weights and products, then the division steps
// depends on cbz_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbz_ctrl
  import cbz_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cbz_cmd_t      cmd
);

  state_t         state, state_next;
  logic           out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '{accept: 1'b0, op: OP_NONE, div_est: 1'b0, div_rem: 1'b0,
                     div_fix: 1'b0, out_load: 1'b0};
    in_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_AA;
        end
      end
      ST_AA: begin
        cmd.op = OP_AA;
        state_next = ST_KK;
      end
      ST_KK: begin
        cmd.op = OP_KK;
        state_next = ST_AK3;
      end
      ST_AK3: begin
        cmd.op = OP_AK3;
        state_next = ST_W0;
      end
      ST_W0: begin
        cmd.op = OP_W0;
        state_next = ST_W3;
      end
      ST_W3: begin
        cmd.op = OP_W3;
        state_next = ST_W1;
      end
      ST_W1: begin
        cmd.op = OP_W1;
        state_next = ST_W2;
      end
      ST_W2: begin
        cmd.op = OP_W2;
        state_next = ST_P0X;
      end
      ST_P0X: begin
        cmd.op = OP_P0X;
        state_next = ST_P1X;
      end
      ST_P1X: begin
        cmd.op = OP_P1X;
        state_next = ST_P2X;
      end
      ST_P2X: begin
        cmd.op = OP_P2X;
        state_next = ST_P3X;
      end
      ST_P3X: begin
        cmd.op = OP_P3X;
        state_next = ST_P0Y;
      end
      ST_P0Y: begin
        cmd.op = OP_P0Y;
        state_next = ST_P1Y;
      end
      ST_P1Y: begin
        cmd.op = OP_P1Y;
        state_next = ST_P2Y;
      end
      ST_P2Y: begin
        cmd.op = OP_P2Y;
        state_next = ST_P3Y;
      end
      ST_P3Y: begin
        cmd.op = OP_P3Y;
        state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        // last product lands in the y sum this cycle
        state_next = ST_DIV_EST;
      end
      ST_DIV_EST: begin
        cmd.div_est = 1'b1;
        state_next  = ST_DIV_REM;
      end
      ST_DIV_REM: begin
        cmd.div_rem = 1'b1;
        state_next  = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cbz_datapath.sv
// cubic bezier point generator: step counter, shared multiplier, accumulators, division
// computes the Bernstein sums exactly and divides them by steps cubed by reciprocal estimate
// depends on cbz_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbz_datapath
  import cbz_pkg::*;
#(
  parameter int STEPS = 200
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cbz_cmd_t             cmd,
  input  wire logic                 restart,
  input  wire logic [3:0][PW-1:0]   ctrl_x,
  input  wire logic [3:0][PW-1:0]   ctrl_y,
  output logic      [PW-1:0]        point_x,
  output logic      [PW-1:0]        point_y,
  output logic                      last
);

  localparam logic [KW-1:0] STEPS_K = KW'(STEPS);
  localparam int            DEN_I   = STEPS * STEPS * STEPS;
  localparam logic [SW-1:0] DEN     = SW'(DEN_I);
  localparam logic [SW-1:0] DEN2    = SW'(2 * DEN_I);
  // sum shifted right by floor(log2 den) is below 2^(PW+1)
  localparam int            DEN_SHIFT = $clog2(DEN_I + 1) - 1;
  localparam int            HW        = PW + 1;
  localparam int            RCP_SHIFT = PW + 2;
  localparam int            RW        = RCP_SHIFT + 1;
  localparam int            EW        = HW + RW;
  localparam longint        RCP_L     = (longint'(1) << (RCP_SHIFT + DEN_SHIFT)) / DEN_I;
  localparam logic [RW-1:0] RCP       = RW'(RCP_L);

  logic [KW-1:0] step_index;
  logic [KW-1:0] k_sel;
  logic [KW-1:0] k, a;
  logic [PW-1:0] k3;
  logic          last_q;

  logic [IW-1:0] aa, kk, ak3;
  logic [WW-1:0] w0, w1, w2, w3;

  logic [WW-1:0] mul_a;
  logic [PW-1:0] mul_b;
  logic [SW-1:0] product;
  logic [SW-1:0] mul_q;
  mul_op_t       op_q;

  logic [SW-1:0] sum_x, sum_y;
  logic [HW-1:0] hx, hy;
  logic [EW-1:0] est_x, est_y;
  logic [SW-1:0] rem_x, rem_y;
  logic [PW-1:0] qx, qy;

  // curve parameter for this item; an out-of-range count restarts the curve
  always_comb begin
    k_sel = '0;
    if (!restart && step_index <= STEPS_K) begin
      k_sel = step_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= '0;
    end else if (cmd.accept) begin
      step_index <= (k_sel >= STEPS_K) ? '0 : k_sel + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k      <= k_sel;
      a      <= STEPS_K - k_sel;
      k3     <= {2'b00, k_sel} + {1'b0, k_sel, 1'b0};
      last_q <= (k_sel == STEPS_K);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_AA: begin
        mul_a = WW'(a);
        mul_b = PW'(a);
      end
      OP_KK: begin
        mul_a = WW'(k);
        mul_b = PW'(k);
      end
      OP_AK3: begin
        mul_a = WW'(a);
        mul_b = k3;
      end
      OP_W0: begin
        mul_a = WW'(aa);
        mul_b = PW'(a);
      end
      OP_W3: begin
        mul_a = WW'(kk);
        mul_b = PW'(k);
      end
      OP_W1: begin
        mul_a = WW'(ak3);
        mul_b = PW'(a);
      end
      OP_W2: begin
        mul_a = WW'(ak3);
        mul_b = PW'(k);
      end
      OP_P0X: begin
        mul_a = w0;
        mul_b = ctrl_x[0];
      end
      OP_P1X: begin
        mul_a = w1;
        mul_b = ctrl_x[1];
      end
      OP_P2X: begin
        mul_a = w2;
        mul_b = ctrl_x[2];
      end
      OP_P3X: begin
        mul_a = w3;
        mul_b = ctrl_x[3];
      end
      OP_P0Y: begin
        mul_a = w0;
        mul_b = ctrl_y[0];
      end
      OP_P1Y: begin
        mul_a = w1;
        mul_b = ctrl_y[1];
      end
      OP_P2Y: begin
        mul_a = w2;
        mul_b = ctrl_y[2];
      end
      OP_P3Y: begin
        mul_a = w3;
        mul_b = ctrl_y[3];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = SW'(mul_a) * SW'(mul_b);

  always_ff @(posedge clk) begin
    mul_q <= product;
    case (cmd.op)
      OP_AA:   aa  <= product[IW-1:0];
      OP_KK:   kk  <= product[IW-1:0];
      OP_AK3:  ak3 <= product[IW-1:0];
      OP_W0:   w0  <= product[WW-1:0];
      OP_W3:   w3  <= product[WW-1:0];
      OP_W1:   w1  <= product[WW-1:0];
      OP_W2:   w2  <= product[WW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= OP_NONE;
    end else begin
      op_q <= cmd.op;
    end
  end

  // accumulate the registered product in the cycle after the multiply
  always_ff @(posedge clk) begin
    case (op_q)
      OP_P0X:                   sum_x <= mul_q;
      OP_P1X, OP_P2X, OP_P3X:   sum_x <= sum_x + mul_q;
      OP_P0Y:                   sum_y <= mul_q;
      OP_P1Y, OP_P2Y, OP_P3Y:   sum_y <= sum_y + mul_q;
      default: ;
    endcase
  end

  // reciprocal estimate lands at most two below the true quotient
  assign hx    = HW'(sum_x >> DEN_SHIFT);
  assign hy    = HW'(sum_y >> DEN_SHIFT);
  assign est_x = EW'(hx) * EW'(RCP);
  assign est_y = EW'(hy) * EW'(RCP);

  // estimate, remainder, then bump the quotient by what the remainder still holds
  always_ff @(posedge clk) begin
    if (cmd.div_est) begin
      qx <= PW'(est_x >> RCP_SHIFT);
      qy <= PW'(est_y >> RCP_SHIFT);
    end else if (cmd.div_rem) begin
      rem_x <= sum_x - SW'(qx) * DEN;
      rem_y <= sum_y - SW'(qy) * DEN;
    end else if (cmd.div_fix) begin
      if (rem_x >= DEN2) begin
        qx <= qx + PW'(2);
      end else if (rem_x >= DEN) begin
        qx <= qx + PW'(1);
      end
      if (rem_y >= DEN2) begin
        qy <= qy + PW'(2);
      end else if (rem_y >= DEN) begin
        qy <= qy + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      point_x <= qx;
      point_y <= qy;
      last    <= last_q;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cubic_bezier_point_generator.sv
// cubic bezier point generator: top level with control point registers
// instantiates cbz_ctrl and cbz_datapath, depends on cbz_pkg
//
//   port group   direction   handshake              payload
//   input        in          in_valid / in_ready    restart
//   result       out         out_valid / out_ready  point_x, point_y, last
//   config       in          cfg_we                 cfg_index, cfg_data
//
// one item at a time: a transfer is taken in the idle state, 15 products run through
// the single shared 24x10 multiplier, a flush state adds the last product to the sum,
// the division by steps cubed does reciprocal estimate, remainder and quotient bump,
// and the done state loads the output register, after which in_ready rises again
// reset clears the step counter, the control points and the sequencer
// a result not yet taken holds the sequencer in its final state, the next input waits
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_point_generator
  import cbz_pkg::*;
#(
  parameter int STEPS = 200
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           restart,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [PW-1:0]       point_x,
  output logic [PW-1:0]       point_y,
  output logic                last,
  input  wire logic           cfg_we,
  input  wire logic [CIW-1:0] cfg_index,
  input  wire logic [PW-1:0]  cfg_data
);

  logic [3:0][PW-1:0] ctrl_x;
  logic [3:0][PW-1:0] ctrl_y;
  cbz_cmd_t           cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_x <= '0;
      ctrl_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X0:  ctrl_x[0] <= cfg_data;
        REG_X1:  ctrl_x[1] <= cfg_data;
        REG_X2:  ctrl_x[2] <= cfg_data;
        REG_X3:  ctrl_x[3] <= cfg_data;
        REG_Y0:  ctrl_y[0] <= cfg_data;
        REG_Y1:  ctrl_y[1] <= cfg_data;
        REG_Y2:  ctrl_y[2] <= cfg_data;
        REG_Y3:  ctrl_y[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  cbz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cbz_datapath #(
    .STEPS (STEPS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .restart (restart),
    .ctrl_x  (ctrl_x),
    .ctrl_y  (ctrl_y),
    .point_x (point_x),
    .point_y (point_y),
    .last    (last)
  );

`ifndef SYNTHESIS
  // only one item in flight
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register loaded while full");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // no new item starts while the sequencer still holds a result
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> (in_valid && !cmd.out_load && !cmd.div_fix))
    else $error("accept outside idle");
`endif

endmodule

`default_nettype wire

### tb/tb_cubic_bezier_point_generator.sv
// testbench for cubic_bezier_point_generator: directed table then random curve sweeps
// checks every point against an integer bernstein predictor; needs cbz_pkg and the rtl
`timescale 1ns / 1ps

module tb_cubic_bezier_point_generator;
  import cbz_pkg::*;

  localparam int STEPS = 200;
  localparam int ITEM_TARGET = 1950;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int N_PLAN = 34;

  localparam bit ADVANCE = 1'b0;
  localparam bit RESTART = 1'b1;
  localparam logic [PW-1:0] COORD_MAX = '1;
  // indexes past the register list, writes there must be dropped
  localparam logic [CIW-1:0] REG_SPARE_FIRST = REG_Y3 + 1'b1;
  localparam logic [CIW-1:0] REG_SPARE_LAST = '1;

  typedef struct {
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic          last;
  } point_t;

  typedef struct {
    bit            is_cfg;
    logic [CIW-1:0] idx;
    logic [PW-1:0] data;
    bit            rs;
    bit            typed;
    point_t        pt;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic restart = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CIW-1:0] cfg_index = '0;
  logic [PW-1:0] cfg_data = '0;
  logic in_ready;
  logic out_valid;
  logic [PW-1:0] point_x;
  logic [PW-1:0] point_y;
  logic last;

  // predictor state
  logic [PW-1:0] ctrl_pt [8];
  logic [KW-1:0] step_next;

  point_t pending_points [$];
  plan_row_t plan [N_PLAN];
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;

  cubic_bezier_point_generator #(
    .STEPS(STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .point_x(point_x),
    .point_y(point_y),
    .last(last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // exact bernstein sum over steps cubed, truncated
  function automatic logic [PW-1:0] bernstein_axis(input logic [PW-1:0] p0, p1, p2, p3,
                                                   input int unsigned k);
    longint unsigned a;
    longint unsigned kk;
    longint unsigned acc;
    longint unsigned n3;
    a = longint'(STEPS - k);
    kk = k;
    n3 = longint'(STEPS) * STEPS * STEPS;
    acc = longint'(p0) * a * a * a + 3 * longint'(p1) * a * a * kk
        + 3 * longint'(p2) * a * kk * kk + longint'(p3) * kk * kk * kk;
    return PW'(acc / n3);
  endfunction

  function automatic point_t next_curve_point(input bit rs);
    point_t p;
    int unsigned k;
    k = rs ? 0 : step_next;
    if (k > STEPS) k = 0;
    p.x = bernstein_axis(ctrl_pt[REG_X0[2:0]], ctrl_pt[REG_X1[2:0]],
                         ctrl_pt[REG_X2[2:0]], ctrl_pt[REG_X3[2:0]], k);
    p.y = bernstein_axis(ctrl_pt[REG_Y0[2:0]], ctrl_pt[REG_Y1[2:0]],
                         ctrl_pt[REG_Y2[2:0]], ctrl_pt[REG_Y3[2:0]], k);
    p.last = (k == STEPS);
    step_next = (k >= STEPS) ? '0 : KW'(k + 1);
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CIW-1:0] idx, input logic [PW-1:0] data);
    plan_row_t r;
    r = '{1'b1, idx, data, ADVANCE, 1'b0, '{'0, '0, 1'b0}};
    return r;
  endfunction

  function automatic plan_row_t point_row(input bit rs, input logic [PW-1:0] x, y,
                                          input logic l);
    plan_row_t r;
    r = '{1'b0, '0, '0, rs, 1'b1, '{x, y, l}};
    return r;
  endfunction

  function automatic plan_row_t open_row(input bit rs);
    plan_row_t r;
    r = '{1'b0, '0, '0, rs, 1'b0, '{'0, '0, 1'b0}};
    return r;
  endfunction

  function automatic logic [PW-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return COORD_MAX;
      default: return PW'($urandom);
    endcase
  endfunction

  // leaves cfg_we high, caller lowers it after the group
  task automatic write_reg(input logic [CIW-1:0] idx, input logic [PW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx <= REG_Y3) ctrl_pt[idx[2:0]] = data;
  endtask

  task automatic send_item(input bit rs, input bit typed, input point_t typed_pt);
    point_t want;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    restart <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = next_curve_point(rs);
    if (typed) want = typed_pt;
    pending_points.push_back(want);
    burst_left--;
    items_sent++;
  endtask

  // drop valid, let every point come back, then give the sequencer time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_control_points();
    wait_idle();
    for (int i = REG_X0; i <= REG_Y3; i++) begin
      if ($urandom_range(0, 3) != 0) write_reg(CIW'(i), pick_coord());
    end
    if ($urandom_range(0, 4) == 0)
      write_reg(CIW'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), PW'($urandom));
    cfg_we <= 1'b0;
  endtask

  // receiver stall pattern: full rate, alternate, coin flip, or held off
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ~out_ready;
      2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("point transfer with nothing expected: x=%0d y=%0d last=%0d",
               point_x, point_y, last);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, point_x);
          errors++;
        end
        if (point_y !== want.y) begin
          $error("point_y: expected %0d, got %0d", want.y, point_y);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    bit prev_cfg;
    int run_len;
    point_t none;
    none = '{'0, '0, 1'b0};
    for (int i = 0; i < 8; i++) ctrl_pt[i] = '0;
    step_next = '0;

    plan = '{
      point_row(ADVANCE, '0, '0, 1'b0),           // advance straight out of reset
      point_row(RESTART, '0, '0, 1'b0),
      point_row(ADVANCE, '0, '0, 1'b0),
      cfg_row(REG_X0, COORD_MAX), cfg_row(REG_X1, COORD_MAX),
      cfg_row(REG_X2, COORD_MAX), cfg_row(REG_X3, COORD_MAX),
      cfg_row(REG_Y0, COORD_MAX), cfg_row(REG_Y1, COORD_MAX),
      cfg_row(REG_Y2, COORD_MAX), cfg_row(REG_Y3, COORD_MAX),
      point_row(RESTART, COORD_MAX, COORD_MAX, 1'b0),
      point_row(ADVANCE, COORD_MAX, COORD_MAX, 1'b0),
      point_row(ADVANCE, COORD_MAX, COORD_MAX, 1'b0),
      cfg_row(REG_X1, '0), cfg_row(REG_X2, '0), cfg_row(REG_X3, '0), cfg_row(REG_Y0, '0),
      point_row(RESTART, COORD_MAX, '0, 1'b0),
      open_row(ADVANCE),
      open_row(ADVANCE),
      cfg_row(REG_SPARE_FIRST, '0), cfg_row(REG_SPARE_LAST, '0),
      point_row(RESTART, COORD_MAX, '0, 1'b0),    // spare writes leave the curve alone
      cfg_row(REG_X0, 10'h2AA), cfg_row(REG_X3, 10'h155),
      cfg_row(REG_Y1, 10'h155), cfg_row(REG_Y2, 10'h2AA),
      point_row(RESTART, 10'h2AA, '0, 1'b0),
      open_row(ADVANCE), open_row(ADVANCE), open_row(ADVANCE),
      open_row(ADVANCE), open_row(ADVANCE)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!prev_cfg) wait_idle();
        write_reg(plan[i].idx, plan[i].data);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        send_item(plan[i].rs, plan[i].typed, plan[i].pt);
        prev_cfg = 1'b0;
      end
    end

    // random curves: mostly full sweeps through the end point, some noise
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 1) == 0) load_control_points();
      if ($urandom_range(0, 9) < 7) begin
        run_len = $urandom_range(180, 260);
        send_item(RESTART, 1'b0, none);
        repeat (run_len) send_item(ADVANCE, 1'b0, none);
      end else begin
        repeat ($urandom_range(1, 20)) send_item(1'($urandom_range(0, 1)), 1'b0, none);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cbz_pkg.sv
hw/rtl/cbz_ctrl.sv
hw/rtl/cbz_datapath.sv
hw/rtl/cubic_bezier_point_generator.sv
tb/tb_cubic_bezier_point_generator.sv
